[src/lbc_pkg.sv]
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types, constants and the hash for the LZW byte compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

    localparam int CODE_BITS   = 12;
    localparam int HASH_SLOTS  = 8192;
    localparam int SLOT_BITS   = $clog2(HASH_SLOTS);
    localparam int KEY_BITS    = CODE_BITS + 8;
    localparam int NEXT_BITS   = CODE_BITS + 1;
    localparam int LIMIT_BITS  = 13;
    localparam int EPOCH_BITS  = 8;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR    = 2;
    localparam int FIFO_CNT    = 3;

    localparam logic [31:0] CODE_SPACE = 32'(1) << CODE_BITS;
    localparam logic [31:0] HASH_MULT  = 32'd2654435761;
    localparam logic [NEXT_BITS-1:0] FIRST_FREE = NEXT_BITS'(256);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_word_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] out_code;
        logic                 last_code;
    } out_word_t;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] epoch;
        logic [KEY_BITS-1:0]   key;
        logic [CODE_BITS-1:0]  code;
    } slot_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK
    } state_t;

    typedef struct packed {
        logic accept;
        logic clear_write;
        logic hash_load;
        logic mem_read;
        logic probe_next;
        logic first;
        logic hit;
        logic miss;
    } cmd_t;

    typedef struct packed {
        logic room;
        logic have_prefix;
        logic eom;
        logic epoch_wrap;
        logic slot_live;
        logic key_match;
        logic probes_done;
        logic clear_last;
    } status_t;

    function automatic logic [SLOT_BITS-1:0] slot_of(input logic [KEY_BITS-1:0] key);
        logic [31:0] h;
        h = 32'(key) * HASH_MULT;
        h = h ^ (h >> 15);
        return h[SLOT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

[src/lbc_ctrl.sv]
// ----------------------------------------------------------------------------
// lbc_ctrl
// Sequencer: clearing pass, byte intake, hash, probe read and resolve.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire lbc_pkg::status_t sts,
    output lbc_pkg::cmd_t        cmd
);
    import lbc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid && sts.room)
                    state_next = ST_HASH;
            end
            ST_HASH:
            begin
                if (!sts.have_prefix)
                    state_next = (sts.eom && sts.epoch_wrap) ? ST_CLEAR : ST_IDLE;
                else
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.slot_live && !sts.key_match && !sts.probes_done)
                    state_next = ST_READ;
                else
                    state_next = (sts.eom && sts.epoch_wrap) ? ST_CLEAR : ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_write = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall   = !sts.room;
                cmd.accept = in_valid && sts.room;
            end
            ST_HASH:
            begin
                cmd.first     = !sts.have_prefix;
                cmd.hash_load = sts.have_prefix;
            end
            ST_READ:
            begin
                cmd.mem_read = 1'b1;
            end
            ST_CHECK:
            begin
                if (sts.slot_live && sts.key_match)
                    cmd.hit = 1'b1;
                else if (sts.slot_live && !sts.probes_done)
                    cmd.probe_next = 1'b1;
                else
                    cmd.miss = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/lbc_datapath.sv]
// ----------------------------------------------------------------------------
// lbc_datapath
// Prefix state, hashed dictionary memory with epoch tags, result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lbc_pkg::in_word_t                 in_word,
    output lbc_pkg::out_word_t                     out_word,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    input  wire logic                              cfg_write,
    input  wire logic [lbc_pkg::LIMIT_BITS-1:0]    cfg_data,
    input  wire lbc_pkg::cmd_t                     cmd,
    output lbc_pkg::status_t                       sts
);
    import lbc_pkg::*;

    slot_t mem [HASH_SLOTS];
    slot_t rd_reg;

    logic [LIMIT_BITS-1:0] code_limit_reg;
    logic [CODE_BITS-1:0]  prefix_reg;
    logic                  have_reg;
    logic [NEXT_BITS-1:0]  next_free_reg;
    logic [EPOCH_BITS-1:0] epoch_reg;
    logic [SLOT_BITS-1:0]  clr_reg;
    logic [SLOT_BITS-1:0]  pos_reg;
    logic [SLOT_BITS-1:0]  probe_reg;
    logic [7:0]            byte_reg;
    logic                  eom_reg;
    logic [KEY_BITS-1:0]   key_reg;

    out_word_t             fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR-1:0]   wr_reg;
    logic [FIFO_PTR-1:0]   rdp_reg;
    logic [FIFO_CNT-1:0]   cnt_reg;

    logic                  resolve;
    logic                  push_a;
    logic                  push_b;
    logic                  pop;
    logic [CODE_BITS-1:0]  fin_code;
    logic [31:0]           lim;
    logic                  can_add;
    logic                  insert;
    logic                  mem_we;
    logic [SLOT_BITS-1:0]  mem_wa;
    slot_t                 mem_wd;
    logic [FIFO_PTR-1:0]   wr_b;

    assign resolve  = cmd.first || cmd.hit || cmd.miss;
    assign push_a   = cmd.miss;
    assign push_b   = resolve && eom_reg;
    assign pop      = out_valid && !out_stall;
    assign fin_code = cmd.hit ? rd_reg.code : CODE_BITS'(byte_reg);
    assign lim      = (32'(code_limit_reg) > CODE_SPACE) ? CODE_SPACE : 32'(code_limit_reg);
    assign can_add  = 32'(next_free_reg) < lim;
    assign insert   = cmd.miss && (rd_reg.epoch != epoch_reg) && can_add;
    assign mem_we   = cmd.clear_write || insert;
    assign mem_wa   = cmd.clear_write ? clr_reg : pos_reg;
    assign wr_b     = wr_reg + FIFO_PTR'(push_a);

    always_comb
    begin
        mem_wd = '0;
        if (!cmd.clear_write)
        begin
            mem_wd.epoch = epoch_reg;
            mem_wd.key   = key_reg;
            mem_wd.code  = next_free_reg[CODE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (cmd.mem_read)
            rd_reg <= mem[pos_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= in_word.data_byte;
            eom_reg  <= in_word.end_of_message;
        end
        if (cmd.hash_load)
        begin
            key_reg   <= {prefix_reg, byte_reg};
            pos_reg   <= slot_of({prefix_reg, byte_reg});
            probe_reg <= '0;
        end
        else if (cmd.probe_next)
        begin
            pos_reg   <= pos_reg + SLOT_BITS'(1);
            probe_reg <= probe_reg + SLOT_BITS'(1);
        end
        for (int i = 0; i < FIFO_DEPTH; i++)
        begin
            if (push_a && wr_reg == FIFO_PTR'(i))
                fifo_reg[i] <= '{out_code: prefix_reg, last_code: 1'b0};
            if (push_b && wr_b == FIFO_PTR'(i))
                fifo_reg[i] <= '{out_code: fin_code, last_code: 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_limit_reg <= LIMIT_BITS'(4096);
            prefix_reg     <= '0;
            have_reg       <= 1'b0;
            next_free_reg  <= FIRST_FREE;
            epoch_reg      <= '0;
            clr_reg        <= '0;
            wr_reg         <= '0;
            rdp_reg        <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cfg_write)
                code_limit_reg <= cfg_data;
            if (cmd.clear_write)
            begin
                clr_reg <= clr_reg + SLOT_BITS'(1);
                if (&clr_reg)
                    epoch_reg <= EPOCH_BITS'(1);
            end
            if (insert && !eom_reg)
                next_free_reg <= next_free_reg + NEXT_BITS'(1);
            if (resolve)
            begin
                if (eom_reg)
                begin
                    prefix_reg    <= '0;
                    have_reg      <= 1'b0;
                    next_free_reg <= FIRST_FREE;
                    epoch_reg     <= epoch_reg + EPOCH_BITS'(1);
                end
                else
                begin
                    prefix_reg <= fin_code;
                    have_reg   <= 1'b1;
                end
            end
            wr_reg  <= wr_reg + FIFO_PTR'(push_a) + FIFO_PTR'(push_b);
            rdp_reg <= rdp_reg + FIFO_PTR'(pop);
            cnt_reg <= cnt_reg + FIFO_CNT'(push_a) + FIFO_CNT'(push_b) - FIFO_CNT'(pop);
        end
    end

    assign out_valid = cnt_reg != '0;
    assign out_word  = fifo_reg[rdp_reg];

    always_comb
    begin
        sts             = '0;
        sts.room        = cnt_reg <= FIFO_CNT'(2);
        sts.have_prefix = have_reg;
        sts.eom         = eom_reg;
        sts.epoch_wrap  = &epoch_reg;
        sts.slot_live   = rd_reg.epoch == epoch_reg;
        sts.key_match   = rd_reg.key == key_reg;
        sts.probes_done = &probe_reg;
        sts.clear_last  = &clr_reg;
    end

`ifndef ASSERT_OFF
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FIFO_CNT'(FIFO_DEPTH)) else $error("result queue overflow");
    a_resolve_room: assert property (@(posedge clk) disable iff (!rst_n)
        resolve |-> cnt_reg <= FIFO_CNT'(2)) else $error("resolve without queue room");
    a_code_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(next_free_reg) <= CODE_SPACE) else $error("next code past code space");
    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> epoch_reg != '0) else $error("item accepted before clear done");
`endif

endmodule

`default_nettype wire

[src/lzw_byte_compressor.sv]
// ----------------------------------------------------------------------------
// lzw_byte_compressor
// LZW compressor, one byte per input word, codes out through a small queue.
// ----------------------------------------------------------------------------
// A byte passes through intake, hash, memory read and resolve, with a
// further memory read and resolve for each extra linear probe of the
// 8192-slot dictionary memory; the first byte of a message passes through
// intake and resolve only. Intake waits while more than two codes are queued.
// After reset, and after every 255th message, a clearing pass over all
// 8192 slots runs during which no byte is taken; config writes are taken at
// any time the block is idle.
`default_nettype none

module lzw_byte_compressor (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire lbc_pkg::in_word_t              in_word,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output lbc_pkg::out_word_t                  out_word,
    input  wire logic                           cfg_write,
    input  wire logic [lbc_pkg::LIMIT_BITS-1:0] cfg_data
);
    import lbc_pkg::*;

    cmd_t    cmd;
    status_t sts;

    lbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    lbc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .out_word  (out_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

[tb/tb_lzw_byte_compressor.sv]
// ----------------------------------------------------------------------------
// tb_lzw_byte_compressor
// Self-checking testbench for the LZW byte compressor. A scoreboard keeps its
// own hashed dictionary and predicts the emitted codes. Directed messages
// come first, then random messages under several code limits. Both sides
// idle and stall at random, except during the last code limit.
// ----------------------------------------------------------------------------
`default_nettype none

class lzw_scoreboard;
    localparam int SLOTS = lbc_pkg::HASH_SLOTS;

    bit                 used [SLOTS];
    bit [19:0]          pair_key [SLOTS];
    bit [11:0]          pair_code [SLOTS];
    bit [11:0]          prefix;
    bit                 in_msg;
    int unsigned        next_code;
    int unsigned        limit;
    lbc_pkg::out_word_t codes_due [$];
    int                 errors;

    function new();
        limit = 4096;
        prefix = '0;
        in_msg = 0;
        errors = 0;
        wipe();
    endfunction

    function void wipe();
        foreach (used[i]) used[i] = 0;
        next_code = 256;
    endfunction

    function int unsigned home_slot(bit [19:0] key);
        bit [31:0] h;
        h = 32'(key) * 32'd2654435761;
        h = h ^ (h >> 15);
        return h % SLOTS;
    endfunction

    function void push_code(bit [11:0] c, bit last);
        lbc_pkg::out_word_t w;
        w.out_code = c;
        w.last_code = last;
        codes_due = {codes_due, w};
    endfunction

    function void note_input(lbc_pkg::in_word_t w);
        bit [19:0]   key;
        int unsigned pos;
        int unsigned cap;
        bit          hit;
        if (!in_msg) begin
            prefix = 12'(w.data_byte);
            in_msg = 1;
        end else begin
            key = {prefix, w.data_byte};
            pos = home_slot(key);
            hit = 0;
            for (int n = 0; n < SLOTS && used[pos]; n++) begin
                if (pair_key[pos] == key) begin
                    hit = 1;
                    break;
                end
                pos = (pos + 1) % SLOTS;
            end
            if (hit) begin
                prefix = pair_code[pos];
            end else begin
                push_code(prefix, 0);
                cap = (limit > 4096) ? 4096 : limit;
                if (next_code < cap) begin
                    pos = home_slot(key);
                    for (int n = 0; n < SLOTS; n++) begin
                        if (!used[pos]) begin
                            used[pos] = 1;
                            pair_key[pos] = key;
                            pair_code[pos] = 12'(next_code);
                            next_code++;
                            break;
                        end
                        pos = (pos + 1) % SLOTS;
                    end
                end
                prefix = 12'(w.data_byte);
            end
        end
        if (w.end_of_message) begin
            push_code(prefix, 1);
            prefix = '0;
            in_msg = 0;
            wipe();
        end
    endfunction

    function void check_result(lbc_pkg::out_word_t got);
        lbc_pkg::out_word_t want;
        if (codes_due.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected code %0d last %0b", got.out_code, got.last_code);
            return;
        end
        want = codes_due.pop_front();
        if (got.out_code !== want.out_code || got.last_code !== want.last_code) begin
            errors++;
            if (errors <= 10)
                $display("code mismatch: expected %0d last %0b, got %0d last %0b",
                         want.out_code, want.last_code, got.out_code, got.last_code);
        end
    endfunction
endclass

module tb_lzw_byte_compressor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CYCLES = 3000000;

    logic                           clk = 0;
    logic                           rst_n = 0;
    logic                           in_valid = 0;
    logic                           in_stall;
    lbc_pkg::in_word_t              in_word = '0;
    logic                           out_valid;
    logic                           out_stall = 0;
    lbc_pkg::out_word_t             out_word;
    logic                           cfg_write = 0;
    logic [lbc_pkg::LIMIT_BITS-1:0] cfg_data = '0;

    lzw_scoreboard sb = new();
    int unsigned   cycles = 0;
    bit            calm = 0;
    int            stall_left = 0;
    int            items = 0;

    lzw_byte_compressor uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word (out_word),
        .cfg_write(cfg_write),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_result(out_word);
    end

    always @(negedge clk)
    begin
        if (calm) begin
            out_stall <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 11);
            out_stall <= 1;
        end else begin
            out_stall <= 0;
        end
    end

    task automatic send_byte(input bit [7:0] b, input bit last);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            in_valid = 0;
            repeat (gap) @(negedge clk);
        end
        in_word.data_byte = b;
        in_word.end_of_message = last;
        in_valid = 1;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_input(in_word);
        items++;
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic drain();
        while (sb.codes_due.size() != 0) @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    task automatic set_limit(input bit [12:0] v);
        @(negedge clk);
        cfg_write = 1;
        cfg_data = v;
        @(negedge clk);
        cfg_write = 0;
        sb.limit = v;
    endtask

    task automatic send_message(input int len, input bit narrow);
        bit [7:0] b;
        for (int i = 0; i < len; i++) begin
            if (narrow && $urandom_range(0, 9) != 0)
                b = 8'($urandom_range(0, 3)) ^ 8'hA5;
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b, i == len - 1);
        end
    endtask

    initial
    begin
        bit [12:0] limits [8];
        limits = '{13'd4096, 13'd256, 13'd257, 13'd300, 13'd0, 13'd8191, 13'd100, 13'd1000};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // one-byte messages and extremes
        send_byte(8'h00, 1);
        send_byte(8'hFF, 1);
        send_byte(8'h00, 0);
        send_byte(8'hFF, 1);
        for (int i = 0; i < 8; i++)
            send_byte(8'h41, i == 7);
        send_byte(8'h55, 0);
        send_byte(8'hAA, 0);
        send_byte(8'h55, 0);
        send_byte(8'hAA, 0);
        send_byte(8'h55, 0);
        send_byte(8'hAA, 1);
        drain();

        for (int p = 0; p < 8; p++) begin
            set_limit(limits[p]);
            if (p == 7)
                calm = 1;
            while (items < 40 + 165 * (p + 1)) begin
                if ($urandom_range(0, 9) == 0)
                    send_message($urandom_range(1, 3), 0);
                else
                    send_message($urandom_range(4, 60), $urandom_range(0, 4) != 0);
            end
            drain();
        end

        if (sb.errors == 0 && sb.codes_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire

[lzw_byte_compressor.f]
src/lbc_pkg.sv
src/lbc_ctrl.sv
src/lbc_datapath.sv
src/lzw_byte_compressor.sv
tb/tb_lzw_byte_compressor.sv
